FILE: sv/tgr_pkg.sv
// shared types, constants and event codes of the touch gesture recognizer
package tgr_pkg;

  // default geometry
  localparam int TG_SLOTS      = 5;
  localparam int TG_COORD_BITS = 12;

  // fixed field widths
  localparam int GEST_W  = 3;
  localparam int POS_W   = 12;
  localparam int OFS_W   = 13;
  localparam int DIST_W  = 13;
  localparam int DELTA_W = 14;
  localparam int WIN_W   = 16;
  localparam int FCNT_W  = 4;
  localparam int RCNT_W  = 8;
  localparam int EV_W    = 16;
  localparam int VAL_W   = 32;

  localparam logic [WIN_W-1:0]  WIN_RESET = 16'd200;
  localparam logic [OFS_W-1:0]  OFS_MAX   = 13'd4095;
  localparam logic [DIST_W-1:0] DIST_MAX  = 13'd8191;
  localparam logic [FCNT_W-1:0] FCNT_MAX  = 4'd15;
  localparam logic [RCNT_W-1:0] RCNT_MAX  = 8'd255;

  // event types and codes
  localparam logic [EV_W-1:0] EV_SYN     = 16'd0;
  localparam logic [EV_W-1:0] EV_KEY     = 16'd1;
  localparam logic [EV_W-1:0] EV_ABS     = 16'd3;
  localparam logic [EV_W-1:0] SYNC_FRAME = 16'd0;
  localparam logic [EV_W-1:0] TOUCH_KEY  = 16'd330;
  localparam logic [EV_W-1:0] ABS_SLOT   = 16'd47;
  localparam logic [EV_W-1:0] ABS_POS_X  = 16'd53;
  localparam logic [EV_W-1:0] ABS_POS_Y  = 16'd54;
  localparam logic [EV_W-1:0] ABS_TRK_ID = 16'd57;

  typedef enum logic [1:0] {
    MODE_RELEASED, MODE_PRESSED, MODE_MOVING, MODE_OTHER
  } mode_t;

  typedef enum logic [1:0] {
    SEEN_NONE, SEEN_PINCH, SEEN_MOVE
  } seen_t;

  typedef enum logic [GEST_W-1:0] {
    G_MOVE, G_MAGNIFY, G_SHRINK, G_CLICK, G_DCLICK
  } gest_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQ, ST_ROOT_INIT, ST_ROOT, ST_PINCH, ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic  coord_wr;
    logic  axis;
    logic  slot_ld;
    logic  clear;
    logic  latch_press;
    logic  move_rep;
    logic  pinch_start;
    logic  sq;
    logic  root_init;
    logic  root_step;
    logic  pinch_fin;
    logic  out_load;
    gest_t gesture;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_nz;
    logic dist_gt;
    logic out_free;
  } status_t;

endpackage

FILE: sv/tgr_if.sv
// channel interfaces: input events, gesture results, configuration writes
interface tgr_in_if;
  import tgr_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic [EV_W-1:0]         ev_type;
  logic [EV_W-1:0]         ev_code;
  logic signed [VAL_W-1:0] ev_value;
  modport source (output valid, kind, ev_type, ev_code, ev_value, input ready);
  modport sink (input valid, kind, ev_type, ev_code, ev_value, output ready);
endinterface

interface tgr_out_if;
  import tgr_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [GEST_W-1:0]         gesture;
  logic [POS_W-1:0]          pos_x;
  logic [POS_W-1:0]          pos_y;
  logic signed [OFS_W-1:0]   move_dx;
  logic signed [OFS_W-1:0]   move_dy;
  logic [POS_W-1:0]          mid_x;
  logic [POS_W-1:0]          mid_y;
  logic signed [DELTA_W-1:0] distance_delta;
  modport source (output valid, gesture, pos_x, pos_y, move_dx, move_dy, mid_x,
                  mid_y, distance_delta, input ready);
  modport sink (input valid, gesture, pos_x, pos_y, move_dx, move_dy, mid_x,
                mid_y, distance_delta, output ready);
endinterface

interface tgr_cfg_if;
  import tgr_pkg::*;
  logic             valid;
  logic             ready;
  logic [WIN_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: sv/touch_gesture_recognizer.sv
// top level of the touch gesture recognizer
//
//  channel  | dir | handshake     | payload
//  in_ch    | in  | valid / ready | kind, ev_type, ev_code, ev_value
//  out_ch   | out | valid / ready | gesture, pos_x/y, move_dx/dy, mid_x/y, distance_delta
//  cfg_ch   | in  | valid / ready | data = click_window_ticks (always ready)
//
// a plain event or a tick is handled in ST_IDLE; a move frame or a click tick then loads
// the output register from ST_EMIT; a pinch frame runs ST_SQ, ST_ROOT_INIT, the ST_ROOT
// steps (one root bit per cycle) and ST_PINCH, then ST_EMIT when it reports
// a result sits in the output register; a new transaction is taken while it waits,
// unless that transaction also makes a result, which then holds until out_ch drains
// reset (rst_n low, synchronous) clears the control state, slot store and report registers
// and sets the window to 200 ticks; no clearing pass is needed after reset
module touch_gesture_recognizer import tgr_pkg::*; #(
  parameter int SLOTS      = TG_SLOTS,
  parameter int COORD_BITS = TG_COORD_BITS
) (
  input logic         clk,
  input logic         rst_n,
  tgr_in_if.sink      in_ch,
  tgr_out_if.source   out_ch,
  tgr_cfg_if.sink     cfg_ch
);

  cmd_t    cmd;
  status_t status;

  // control
  tgr_ctrl #(
    .COORD_BITS(COORD_BITS)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .status (status),
    .cmd    (cmd)
  );

  // storage and arithmetic
  tgr_dp #(
    .SLOTS      (SLOTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .ev_value (in_ch.ev_value),
    .status   (status),
    .out_ch   (out_ch)
  );

endmodule

FILE: sv/tgr_dp.sv
// datapath: slot coordinates, report registers, square root unit, output register
module tgr_dp import tgr_pkg::*; #(
  parameter int SLOTS      = TG_SLOTS,
  parameter int COORD_BITS = TG_COORD_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cmd_t                    cmd,
  input  logic signed [VAL_W-1:0] ev_value,
  output status_t                 status,
  tgr_out_if.source               out_ch
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SQ_W   = 2 * COORD_BITS + 2;
  localparam int DIFF_W = COORD_BITS + OFS_W;
  localparam logic signed [VAL_W-1:0] CMAX   = VAL_W'((64'd1 << COORD_BITS) - 64'd1);
  localparam logic signed [VAL_W-1:0] NSLOTS = VAL_W'(SLOTS);

  logic [COORD_BITS-1:0] new_c_r [SLOTS][2];
  logic [COORD_BITS-1:0] old_c_r [SLOTS][2];
  logic [SLOT_W-1:0]     slot_r;
  logic [DIST_W-1:0]     last_dist_r;

  logic [POS_W-1:0]          rep_px_r, rep_py_r, rep_cx_r, rep_cy_r;
  logic signed [OFS_W-1:0]   rep_dx_r, rep_dy_r;
  logic signed [DELTA_W-1:0] rep_dd_r;

  logic [COORD_BITS-1:0] adx_r, ady_r;
  logic [2*COORD_BITS-1:0] sqx_r, sqy_r;
  logic [SQ_W-1:0] rem_r, root_r, bit_r;

  logic                      out_valid_r;
  logic [GEST_W-1:0]         out_gest_r;
  logic [POS_W-1:0]          out_px_r, out_py_r, out_cx_r, out_cy_r;
  logic signed [OFS_W-1:0]   out_dx_r, out_dy_r;
  logic signed [DELTA_W-1:0] out_dd_r;

  logic [COORD_BITS-1:0]   cval;
  logic [COORD_BITS-1:0]   ax_new, ay_new, ax_old, ay_old;
  logic signed [DIFF_W-1:0] mdx, mdy;
  logic signed [OFS_W-1:0] mdx_sat, mdy_sat;
  logic signed [COORD_BITS:0] pdx, pdy;
  logic [SQ_W:0]           trial;
  logic [DIST_W-1:0]       dist_now;
  logic [COORD_BITS:0]     csum_x, csum_y;
  logic                    slot_ok;

  // coordinate saturation of the event value
  always_comb begin
    if (ev_value < 0) cval = '0;
    else if (ev_value > CMAX) cval = CMAX[COORD_BITS-1:0];
    else cval = ev_value[COORD_BITS-1:0];
  end

  assign slot_ok = (ev_value >= 0) && (ev_value < NSLOTS);

  // single-finger offsets, saturated
  assign ax_new = new_c_r[slot_r][0];
  assign ay_new = new_c_r[slot_r][1];
  assign ax_old = old_c_r[slot_r][0];
  assign ay_old = old_c_r[slot_r][1];
  assign mdx = $signed(DIFF_W'(ax_new)) - $signed(DIFF_W'(ax_old));
  assign mdy = $signed(DIFF_W'(ay_new)) - $signed(DIFF_W'(ay_old));

  always_comb begin
    if (mdx > $signed(DIFF_W'(OFS_MAX))) mdx_sat = $signed(OFS_MAX);
    else if (mdx < -$signed(DIFF_W'(OFS_MAX))) mdx_sat = -$signed(OFS_MAX);
    else mdx_sat = mdx[OFS_W-1:0];
    if (mdy > $signed(DIFF_W'(OFS_MAX))) mdy_sat = $signed(OFS_MAX);
    else if (mdy < -$signed(DIFF_W'(OFS_MAX))) mdy_sat = -$signed(OFS_MAX);
    else mdy_sat = mdy[OFS_W-1:0];
  end

  // pinch distance between slot 0 and slot 1
  assign pdx = $signed({1'b0, new_c_r[1][0]}) - $signed({1'b0, new_c_r[0][0]});
  assign pdy = $signed({1'b0, new_c_r[1][1]}) - $signed({1'b0, new_c_r[0][1]});
  assign trial = {1'b0, root_r} + {1'b0, bit_r};
  assign dist_now = (root_r > SQ_W'(DIST_MAX)) ? DIST_MAX : root_r[DIST_W-1:0];
  assign csum_x = {1'b0, new_c_r[0][0]} + {1'b0, new_c_r[1][0]};
  assign csum_y = {1'b0, new_c_r[0][1]} + {1'b0, new_c_r[1][1]};

  assign status.last_nz  = (last_dist_r != '0);
  assign status.dist_gt  = (dist_now > last_dist_r);
  assign status.out_free = !out_valid_r || out_ch.ready;

  // slot coordinate store
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int s = 0; s < SLOTS; s++) begin
        new_c_r[s][0] <= '0;
        new_c_r[s][1] <= '0;
        old_c_r[s][0] <= '0;
        old_c_r[s][1] <= '0;
      end
      last_dist_r <= '0;
    end else begin
      if (cmd.coord_wr) begin
        old_c_r[slot_r][cmd.axis] <= new_c_r[slot_r][cmd.axis];
        new_c_r[slot_r][cmd.axis] <= cval;
      end
      if (cmd.pinch_fin) last_dist_r <= dist_now;
    end
  end

  // active slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else if (cmd.slot_ld && slot_ok) begin
      slot_r <= ev_value[SLOT_W-1:0];
    end
  end

  // latched report registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_px_r <= '0;
      rep_py_r <= '0;
      rep_dx_r <= '0;
      rep_dy_r <= '0;
      rep_cx_r <= '0;
      rep_cy_r <= '0;
      rep_dd_r <= '0;
    end else begin
      if (cmd.latch_press) begin
        rep_px_r <= POS_W'({{POS_W{1'b0}}, new_c_r[0][0]});
        rep_py_r <= POS_W'({{POS_W{1'b0}}, new_c_r[0][1]});
      end
      if (cmd.move_rep) begin
        rep_px_r <= POS_W'({{POS_W{1'b0}}, ax_new});
        rep_py_r <= POS_W'({{POS_W{1'b0}}, ay_new});
        rep_dx_r <= mdx_sat;
        rep_dy_r <= mdy_sat;
      end
      if (cmd.pinch_fin && status.last_nz) begin
        rep_cx_r <= POS_W'({{POS_W{1'b0}}, csum_x[COORD_BITS:1]});
        rep_cy_r <= POS_W'({{POS_W{1'b0}}, csum_y[COORD_BITS:1]});
        rep_dd_r <= $signed({1'b0, dist_now}) - $signed({1'b0, last_dist_r});
      end
    end
  end

  // squares, then one root bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.pinch_start) begin
      adx_r <= pdx[COORD_BITS] ? COORD_BITS'(-pdx) : pdx[COORD_BITS-1:0];
      ady_r <= pdy[COORD_BITS] ? COORD_BITS'(-pdy) : pdy[COORD_BITS-1:0];
    end
    if (cmd.sq) begin
      sqx_r <= adx_r * adx_r;
      sqy_r <= ady_r * ady_r;
    end
    if (cmd.root_init) begin
      rem_r  <= SQ_W'(sqx_r) + SQ_W'(sqy_r);
      root_r <= '0;
      bit_r  <= SQ_W'(1) << (SQ_W - 2);
    end else if (cmd.root_step) begin
      if ({1'b0, rem_r} >= trial) begin
        rem_r  <= rem_r - trial[SQ_W-1:0];
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_gest_r <= cmd.gesture;
      out_px_r   <= rep_px_r;
      out_py_r   <= rep_py_r;
      out_dx_r   <= rep_dx_r;
      out_dy_r   <= rep_dy_r;
      out_cx_r   <= rep_cx_r;
      out_cy_r   <= rep_cy_r;
      out_dd_r   <= rep_dd_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.gesture        = out_gest_r;
  assign out_ch.pos_x          = out_px_r;
  assign out_ch.pos_y          = out_py_r;
  assign out_ch.move_dx        = out_dx_r;
  assign out_ch.move_dy        = out_dy_r;
  assign out_ch.mid_x          = out_cx_r;
  assign out_ch.mid_y          = out_cy_r;
  assign out_ch.distance_delta = out_dd_r;

endmodule

FILE: sv/tgr_ctrl.sv
// controller: event decode, touch state, click window and sequencing of a pinch
module tgr_ctrl import tgr_pkg::*; #(
  parameter int COORD_BITS = TG_COORD_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  tgr_in_if.sink    in_ch,
  tgr_cfg_if.sink   cfg_ch,
  input  status_t   status,
  output cmd_t      cmd
);

  localparam int ROOT_STEPS = COORD_BITS + 1;
  localparam int CNT_W      = $clog2(ROOT_STEPS);

  state_t            state_r, state_nxt;
  mode_t             mode_r, mode_nxt;
  seen_t             seen_r, seen_nxt;
  gest_t             gest_r, gest_nxt;
  logic              fv_r, fv_nxt;
  logic [FCNT_W-1:0] fcnt_r, fcnt_nxt;
  logic [RCNT_W-1:0] rcnt_r, rcnt_nxt;
  logic [WIN_W-1:0]  timer_r, timer_nxt;
  logic [WIN_W-1:0]  win_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              in_fire;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // click window register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= WIN_RESET;
    end else if (cfg_ch.valid) begin
      win_r <= cfg_ch.data;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mode_r  <= MODE_RELEASED;
      seen_r  <= SEEN_NONE;
      gest_r  <= G_MOVE;
      fv_r    <= 1'b0;
      fcnt_r  <= '0;
      rcnt_r  <= '0;
      timer_r <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      seen_r  <= seen_nxt;
      gest_r  <= gest_nxt;
      fv_r    <= fv_nxt;
      fcnt_r  <= fcnt_nxt;
      rcnt_r  <= rcnt_nxt;
      timer_r <= timer_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    seen_nxt    = seen_r;
    gest_nxt    = gest_r;
    fv_nxt      = fv_r;
    fcnt_nxt    = fcnt_r;
    rcnt_nxt    = rcnt_r;
    timer_nxt   = timer_r;
    cnt_nxt     = cnt_r;
    cmd         = '0;
    cmd.gesture = gest_r;
    cmd.axis    = (in_ch.ev_code == ABS_POS_Y);

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.kind) begin
            // millisecond tick runs the click window
            if (timer_r != '0) begin
              timer_nxt = timer_r - 1'b1;
              if (timer_r == WIN_W'(1)) begin
                gest_nxt  = (rcnt_r == RCNT_W'(1)) ? G_CLICK : G_DCLICK;
                rcnt_nxt  = '0;
                state_nxt = ST_EMIT;
              end
            end
          end else begin
            case (in_ch.ev_type)
              EV_KEY: begin
                if (in_ch.ev_code == TOUCH_KEY) begin
                  if (in_ch.ev_value == 0) mode_nxt = MODE_RELEASED;
                  else if (in_ch.ev_value == 1) mode_nxt = MODE_PRESSED;
                  else if (in_ch.ev_value == -1) mode_nxt = MODE_MOVING;
                  else mode_nxt = MODE_OTHER;
                  fv_nxt = 1'b1;
                end
              end
              EV_ABS: begin
                if (in_ch.ev_code == ABS_POS_X || in_ch.ev_code == ABS_POS_Y) begin
                  cmd.coord_wr = 1'b1;
                  fv_nxt       = 1'b1;
                end else if (in_ch.ev_code == ABS_SLOT) begin
                  cmd.slot_ld = 1'b1;
                end else if (in_ch.ev_code == ABS_TRK_ID) begin
                  if (in_ch.ev_value == -1) begin
                    if (fcnt_r != '0) fcnt_nxt = fcnt_r - 1'b1;
                  end else if (fcnt_r != FCNT_MAX) begin
                    fcnt_nxt = fcnt_r + 1'b1;
                  end
                end
              end
              EV_SYN: begin
                if (in_ch.ev_code == SYNC_FRAME && fv_r) begin
                  case (mode_r)
                    MODE_PRESSED: cmd.latch_press = 1'b1;
                    MODE_RELEASED: begin
                      // a release after a pure tap opens the click window
                      if (seen_r == SEEN_NONE) begin
                        if (rcnt_r != RCNT_MAX) rcnt_nxt = rcnt_r + 1'b1;
                        timer_nxt = (win_r != '0) ? win_r : WIN_W'(1);
                      end
                      seen_nxt  = SEEN_NONE;
                      cmd.clear = 1'b1;
                    end
                    MODE_MOVING: begin
                      if (fcnt_r == FCNT_W'(1)) begin
                        seen_nxt     = SEEN_MOVE;
                        cmd.move_rep = 1'b1;
                        gest_nxt     = G_MOVE;
                        state_nxt    = ST_EMIT;
                      end else begin
                        seen_nxt        = SEEN_PINCH;
                        cmd.pinch_start = 1'b1;
                        state_nxt       = ST_SQ;
                      end
                    end
                    default: ;
                  endcase
                  mode_nxt = MODE_MOVING;
                  fv_nxt   = 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
      end
      ST_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = ST_ROOT_INIT;
      end
      ST_ROOT_INIT: begin
        cmd.root_init = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ROOT_STEPS - 1)) state_nxt = ST_PINCH;
      end
      ST_PINCH: begin
        cmd.pinch_fin = 1'b1;
        if (status.last_nz) begin
          gest_nxt  = status.dist_gt ? G_MAGNIFY : G_SHRINK;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // root iteration count stays within the unit's steps
  a_root_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ROOT |-> cnt_r < CNT_W'(ROOT_STEPS))
    else $error("root step count overran");

  // a release frame after a tap leaves the click window running
  a_win_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_ch.kind && in_ch.ev_type == EV_SYN && in_ch.ev_code == SYNC_FRAME
    && fv_r && mode_r == MODE_RELEASED && seen_r == SEEN_NONE |=> timer_r != '0)
    else $error("click window not started");

  // a pending result leaves once the output register is free
  a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT && status.out_free |=> state_r == ST_IDLE)
    else $error("emit did not complete");

  // a pinch always ends with a move into the final pinch step
  a_root_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ROOT && cnt_r == CNT_W'(ROOT_STEPS - 1) |=> state_r == ST_PINCH)
    else $error("root unit did not finish");

endmodule

FILE: verif/tb_top.sv
// self-checking testbench for the touch gesture recognizer
`timescale 1ns / 1ps

module tb_top;
  import tgr_pkg::*;

  // one gesture report as the block delivers it
  typedef struct {
    logic [GEST_W-1:0]         gesture;
    logic [POS_W-1:0]          pos_x;
    logic [POS_W-1:0]          pos_y;
    logic signed [OFS_W-1:0]   move_dx;
    logic signed [OFS_W-1:0]   move_dy;
    logic [POS_W-1:0]          mid_x;
    logic [POS_W-1:0]          mid_y;
    logic signed [DELTA_W-1:0] distance_delta;
  } report_t;

  // one input event or tick
  typedef struct {
    logic                    kind;
    logic [EV_W-1:0]         ev_type;
    logic [EV_W-1:0]         ev_code;
    logic signed [VAL_W-1:0] ev_value;
  } event_t;

  // one row of the directed table
  typedef struct {
    event_t            ev;
    bit                chk;
    logic [GEST_W-1:0] gest;
  } row_t;

  logic clk;
  logic rst_n;
  tgr_in_if  in_ch ();
  tgr_out_if out_ch ();
  tgr_cfg_if cfg_ch ();

  touch_gesture_recognizer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  // predictor state
  logic [WIN_W-1:0]  win_ticks;
  mode_t             mode;
  bit                frame_dirty;
  int                fingers;
  int                slot_sel;
  int                cur_xy  [TG_SLOTS][2];
  int                prev_xy [TG_SLOTS][2];
  int                prev_dist;
  seen_t             seen;
  int                releases;
  int                win_left;
  report_t           latched;

  report_t expected_reports[$];
  int      errors;
  int      idle_cycles;
  int      burst_left;
  bit      stim_done;
  bit      hold_off;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int floor_sqrt(int v);
    int r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r = r + 1;
    return r;
  endfunction

  function automatic void gesture_reset();
    win_ticks   = WIN_RESET;
    mode        = MODE_RELEASED;
    frame_dirty = 0;
    fingers     = 0;
    slot_sel    = 0;
    cur_xy      = '{default: '{0, 0}};
    prev_xy     = '{default: '{0, 0}};
    prev_dist   = 0;
    seen        = SEEN_NONE;
    releases    = 0;
    win_left    = 0;
    latched     = '{default: '0};
  endfunction

  function automatic void push_report(logic [GEST_W-1:0] g);
    report_t r;
    r = latched;
    r.gesture = g;
    expected_reports.push_back(r);
  endfunction

  function automatic int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // frame end: decide the gesture from the touch state
  function automatic void predict_sync();
    int dx, dy, cur_dist;
    int s;
    if (!frame_dirty) return;
    case (mode)
      MODE_PRESSED: begin
        latched.pos_x = POS_W'(cur_xy[0][0]);
        latched.pos_y = POS_W'(cur_xy[0][1]);
      end
      MODE_RELEASED: begin
        if (seen == SEEN_NONE) begin
          if (releases < 255) releases++;
          win_left = (win_ticks == 0) ? 1 : int'(win_ticks);
        end
        seen      = SEEN_NONE;
        cur_xy    = '{default: '{0, 0}};
        prev_xy   = '{default: '{0, 0}};
        prev_dist = 0;
      end
      MODE_MOVING: begin
        if (fingers == 1) begin
          s = slot_sel;
          seen = SEEN_MOVE;
          latched.pos_x   = POS_W'(cur_xy[s][0]);
          latched.pos_y   = POS_W'(cur_xy[s][1]);
          latched.move_dx = OFS_W'(clamp(cur_xy[s][0] - prev_xy[s][0], -4095, 4095));
          latched.move_dy = OFS_W'(clamp(cur_xy[s][1] - prev_xy[s][1], -4095, 4095));
          push_report(G_MOVE);
        end else begin
          dx       = cur_xy[1][0] - cur_xy[0][0];
          dy       = cur_xy[1][1] - cur_xy[0][1];
          cur_dist = floor_sqrt(dx * dx + dy * dy);
          if (cur_dist > 8191) cur_dist = 8191;
          seen = SEEN_PINCH;
          if (prev_dist != 0) begin
            latched.mid_x          = POS_W'((cur_xy[0][0] + cur_xy[1][0]) / 2);
            latched.mid_y          = POS_W'((cur_xy[0][1] + cur_xy[1][1]) / 2);
            latched.distance_delta = DELTA_W'(cur_dist - prev_dist);
            push_report(cur_dist > prev_dist ? G_MAGNIFY : G_SHRINK);
          end
          prev_dist = cur_dist;
        end
      end
      default: ;
    endcase
    mode        = MODE_MOVING;
    frame_dirty = 0;
  endfunction

  function automatic void predict_event(event_t e);
    int a;
    if (e.kind) begin
      if (win_left == 0) return;
      win_left--;
      if (win_left != 0) return;
      push_report(releases == 1 ? G_CLICK : G_DCLICK);
      releases = 0;
      return;
    end
    if (e.ev_type == EV_KEY && e.ev_code == TOUCH_KEY) begin
      if (e.ev_value == 0) mode = MODE_RELEASED;
      else if (e.ev_value == 1) mode = MODE_PRESSED;
      else if (e.ev_value == -1) mode = MODE_MOVING;
      else mode = MODE_OTHER;
      frame_dirty = 1;
    end else if (e.ev_type == EV_ABS) begin
      if (e.ev_code == ABS_POS_X || e.ev_code == ABS_POS_Y) begin
        a = (e.ev_code == ABS_POS_Y) ? 1 : 0;
        prev_xy[slot_sel][a] = cur_xy[slot_sel][a];
        cur_xy[slot_sel][a]  = clamp(e.ev_value, 0, 4095);
        frame_dirty = 1;
      end else if (e.ev_code == ABS_SLOT) begin
        if (e.ev_value >= 0 && e.ev_value < TG_SLOTS) slot_sel = e.ev_value;
      end else if (e.ev_code == ABS_TRK_ID) begin
        if (e.ev_value == -1) begin
          if (fingers > 0) fingers--;
        end else if (fingers < 15) fingers++;
      end
    end else if (e.ev_type == EV_SYN && e.ev_code == SYNC_FRAME) begin
      predict_sync();
    end
  endfunction

  function automatic event_t mk(logic [EV_W-1:0] t, logic [EV_W-1:0] c, int v);
    event_t e;
    e.kind = 1'b0; e.ev_type = t; e.ev_code = c; e.ev_value = v;
    return e;
  endfunction

  function automatic event_t tick_ev();
    event_t e;
    e = mk(EV_SYN, SYNC_FRAME, 0);
    e.kind = 1'b1;
    e.ev_type = EV_W'($urandom); e.ev_code = EV_W'($urandom); e.ev_value = $urandom;
    return e;
  endfunction

  // drive one transaction inside a burst, with a random gap between bursts
  task automatic send_event(event_t e);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    burst_left--;
    in_ch.valid    <= 1'b1;
    in_ch.kind     <= e.kind;
    in_ch.ev_type  <= e.ev_type;
    in_ch.ev_code  <= e.ev_code;
    in_ch.ev_value <= e.ev_value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_event(e);
  endtask

  task automatic drain_and_config(logic [WIN_W-1:0] w);
    in_ch.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= w;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    win_ticks = w;
  endtask

  // random frames, tick runs and malformed events
  task automatic random_frame();
    int k, n;
    k = $urandom_range(0, 9);
    if (k < 3) begin
      send_event(mk(EV_ABS, ABS_SLOT, $urandom_range(0, 1)));
      send_event(mk(EV_ABS, ABS_POS_X, $urandom_range(0, 4095)));
      send_event(mk(EV_ABS, ABS_POS_Y, $urandom_range(0, 4095)));
      send_event(mk(EV_SYN, SYNC_FRAME, 0));
    end else if (k < 5) begin
      send_event(mk(EV_ABS, ABS_TRK_ID, $urandom_range(0, 1) ? -1 : $urandom_range(0, 99)));
      send_event(mk(EV_KEY, TOUCH_KEY, int'($urandom_range(0, 2)) - 1));
      send_event(mk(EV_SYN, SYNC_FRAME, 0));
    end else if (k < 7) begin
      n = $urandom_range(1, 8);
      repeat (n) send_event(tick_ev());
    end else if (k < 8) begin
      send_event(mk(EV_ABS, ABS_POS_X, $urandom));
      send_event(mk(EV_ABS, ABS_SLOT, $urandom_range(0, 7)));
      send_event(mk(EV_SYN, SYNC_FRAME, 0));
    end else begin
      send_event(mk(EV_W'($urandom_range(0, 4)),
                    $urandom_range(0, 1) ? EV_W'($urandom) : TOUCH_KEY, $urandom));
    end
  endtask

  // receiver: random stall pattern plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= !hold_off && ($urandom_range(0, 3) != 0);
  end

  // result checker
  always @(posedge clk) begin
    report_t x;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_reports.size() == 0) begin
        $error("unexpected report gesture=%0d", out_ch.gesture);
        errors++;
      end else begin
        x = expected_reports.pop_front();
        if (out_ch.gesture !== x.gesture) begin
          $error("gesture exp %0d got %0d", x.gesture, out_ch.gesture); errors++; end
        if (out_ch.pos_x !== x.pos_x) begin
          $error("pos_x exp %0d got %0d", x.pos_x, out_ch.pos_x); errors++; end
        if (out_ch.pos_y !== x.pos_y) begin
          $error("pos_y exp %0d got %0d", x.pos_y, out_ch.pos_y); errors++; end
        if (out_ch.move_dx !== x.move_dx) begin
          $error("move_dx exp %0d got %0d", x.move_dx, out_ch.move_dx); errors++; end
        if (out_ch.move_dy !== x.move_dy) begin
          $error("move_dy exp %0d got %0d", x.move_dy, out_ch.move_dy); errors++; end
        if (out_ch.mid_x !== x.mid_x) begin
          $error("mid_x exp %0d got %0d", x.mid_x, out_ch.mid_x); errors++; end
        if (out_ch.mid_y !== x.mid_y) begin
          $error("mid_y exp %0d got %0d", x.mid_y, out_ch.mid_y); errors++; end
        if (out_ch.distance_delta !== x.distance_delta) begin
          $error("distance_delta exp %0d got %0d", x.distance_delta,
                 out_ch.distance_delta);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || hold_off)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // directed rows: press, moves, pinch, release, extremes
  row_t table_rows[$];

  task automatic add_row(event_t e, bit chk = 0, logic [GEST_W-1:0] g = '0);
    row_t r;
    r.ev = e; r.chk = chk; r.gest = g;
    table_rows.push_back(r);
  endtask

  initial begin
    errors = 0; idle_cycles = 0; burst_left = 0; stim_done = 0; hold_off = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0; in_ch.kind = 1'b0; in_ch.ev_type = '0;
    in_ch.ev_code = '0; in_ch.ev_value = '0;
    cfg_ch.valid = 1'b0; cfg_ch.data = '0;
    gesture_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    add_row(mk(EV_ABS, ABS_TRK_ID, 7));
    add_row(mk(EV_ABS, ABS_POS_X, 32'h7fffffff));
    add_row(mk(EV_ABS, ABS_POS_Y, 32'h80000000));
    add_row(mk(EV_KEY, TOUCH_KEY, 1));
    add_row(mk(EV_SYN, SYNC_FRAME, 0));
    add_row(mk(EV_ABS, ABS_POS_X, 0));
    add_row(mk(EV_ABS, ABS_POS_Y, 4095));
    add_row(mk(EV_SYN, SYNC_FRAME, 0), 1, G_MOVE);
    add_row(mk(EV_ABS, ABS_SLOT, 9));
    add_row(mk(EV_ABS, ABS_SLOT, -1));
    add_row(mk(EV_ABS, ABS_TRK_ID, 3));
    add_row(mk(EV_ABS, ABS_SLOT, 1));
    add_row(mk(EV_ABS, ABS_POS_X, 4000));
    add_row(mk(EV_SYN, SYNC_FRAME, 0));
    add_row(mk(EV_ABS, ABS_POS_X, 100));
    add_row(mk(EV_SYN, SYNC_FRAME, 0), 1, G_SHRINK);
    add_row(mk(EV_KEY, TOUCH_KEY, 5));
    add_row(mk(EV_SYN, SYNC_FRAME, 0));
    add_row(mk(EV_KEY, TOUCH_KEY, 0));
    add_row(mk(EV_SYN, SYNC_FRAME, 0));
    add_row(mk(EV_ABS, ABS_TRK_ID, -1));
    add_row(mk(16'hffff, 16'hffff, 0));
    foreach (table_rows[i]) begin
      send_event(table_rows[i].ev);
      if (table_rows[i].chk && expected_reports.size() != 0 &&
          expected_reports[$].gesture !== table_rows[i].gest) begin
        $error("gesture exp %0d got %0d", table_rows[i].gest,
               expected_reports[$].gesture);
        errors++;
      end
    end

    // short window: tap then ticks give a click
    drain_and_config(16'd0);
    send_event(mk(EV_KEY, TOUCH_KEY, 0));
    send_event(mk(EV_SYN, SYNC_FRAME, 0));
    send_event(tick_ev());
    send_event(tick_ev());
    drain_and_config(16'd3);
    for (int p = 0; p < 3; p++) begin
      for (int q = 0; q < 45; q++) begin
        random_frame();
        if (p == 1 && q == 20) begin
          // long receiver hold-off while the sender keeps going
          fork
            begin hold_off = 1; repeat (300) @(posedge clk); hold_off = 0; end
          join_none
        end
      end
      drain_and_config(p == 0 ? 16'hffff : 16'd1);
    end
    stim_done = 1;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
